/* design/assert_macros.svh */
// Assertion macros used by carousel_position_servo_loop.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

/* design/cpsl_pkg.sv */
`timescale 1ns / 1ps

package cpsl_pkg;

  localparam int ANGLE_W   = 16;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 3;
  localparam int SPEED_W   = 8;
  localparam int ERR_W     = 18;
  localparam int LIM_W     = 15;
  localparam int NUM_SLOTS = 7;
  localparam int MAX_SLOTS = 7;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0      = 3'd1;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 3'd7;

  localparam logic signed [ERR_W-1:0] TURN        = 18'sd36000;
  localparam logic signed [ERR_W-1:0] NARROW_BAND = 18'sd50;
  localparam logic signed [ERR_W-1:0] WIDE_BAND   = 18'sd100;
  localparam logic signed [ERR_W-1:0] ERR_CLAMP   = 18'sd18000;
  localparam logic signed [ERR_W-1:0] CRAWL_ZONE  = 18'sd900;

  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 8'sd15;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd80;

  // floor(lim * 65 / 18000) = floor(lim * 13 * RECIP / 2^30) for lim <= 18000,
  // with RECIP = ceil(2^30 / 3600). The product constant is 13 * RECIP.
  localparam int RECIP_W   = 22;
  localparam int RECIP_SH  = 30;
  localparam int PROD_W    = LIM_W + RECIP_W;
  localparam int QUOT_W    = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] SPEED_RECIP = 22'd3877406;

  typedef struct packed {
    logic             outside;
    logic             crawl;
    logic [LIM_W-1:0] lim;
  } decision_t;

  typedef struct packed {
    decision_t         dec;
    logic              ccw;
    logic              settled;
    logic [SLOT_W-1:0] slot;
  } stage_t;

endpackage

/* design/carousel_position_servo_loop.sv */
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tdata: measured_angle, goal_slot, travel_dir; tuser: mode
// m_axis    out        tdata: speed_percent, settled, active_slot
// cfg       in         cfg_we / cfg_addr / cfg_wdata, one register per write
//
// One item per cycle while m_axis is not stalled. The error and the loop flags
// are formed in the cycle of the transfer; the constant multiply that maps error
// to speed runs in the next, on the middle stage, and the result is registered
// onto m_axis. Commands produce no result. rst clears the flags and restores the
// configuration. A stall on m_axis holds the output and fills the middle stage
// before s_tready drops.

module carousel_position_servo_loop
  import cpsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] measured_angle, [18:16] goal_slot, [19] travel_dir, [23:20] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] mode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] speed_percent, [8] settled, [11:9] active_slot, [15:12] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ANGLE_W-1:0]    cfg_wdata
);

`include "assert_macros.svh"

  logic [COUNT_W-1:0] slot_count;
  logic [ANGLE_W-1:0] slot_angle [NUM_SLOTS];

  logic [SLOT_W-1:0] target_slot;
  logic              dir_flag;
  logic              settled_flag;
  logic              moving_flag;
  logic              wide_band_latched;

  logic [ANGLE_W-1:0] meas_angle;
  logic [SLOT_W-1:0]  goal_slot;
  logic               travel_dir;
  logic               cmd_ok;
  logic               in_xfer;
  logic               tick_xfer;
  logic               wide_next;
  logic [ANGLE_W-1:0] ref_angle;
  decision_t          dec;

  logic   mid_valid;
  stage_t mid;
  logic   out_free;
  logic   mid_free;

  logic [PROD_W-1:0]         prod;
  logic [QUOT_W-1:0]         quot;
  logic signed [SPEED_W-1:0] mag;
  logic signed [SPEED_W-1:0] speed_next;

  assign meas_angle = s_tdata[ANGLE_W-1:0];
  assign goal_slot  = s_tdata[ANGLE_W +: SLOT_W];
  assign travel_dir = s_tdata[ANGLE_W + SLOT_W];

  assign out_free  = !m_tvalid || m_tready;
  assign mid_free  = !mid_valid || out_free;
  assign s_tready  = mid_free;
  assign in_xfer   = s_tvalid && s_tready;
  assign tick_xfer = in_xfer && !s_tuser;
  assign cmd_ok    = (COUNT_W'(goal_slot) < slot_count) &&
                     (32'(goal_slot) < MAX_SLOTS);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RST;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_angle[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_addr == REG_SLOT_COUNT) begin
        slot_count <= cfg_wdata[COUNT_W-1:0];
      end else if (cfg_addr >= REG_SLOT0) begin
        slot_angle[cfg_addr - REG_SLOT0] <= cfg_wdata;
      end
    end
  end

  assign ref_angle = (32'(target_slot) < NUM_SLOTS) ? slot_angle[target_slot]
                                                    : slot_angle[0];

  // The band is latched at the first tick of each move.
  assign wide_next = moving_flag ? wide_band_latched : settled_flag;

  cpsl_err u_err (
    .ref_angle  (ref_angle),
    .meas_angle (meas_angle),
    .ccw        (dir_flag),
    .wide_band  (wide_next),
    .dec        (dec)
  );

  // Loop flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_slot       <= '0;
      dir_flag          <= 1'b0;
      settled_flag      <= 1'b0;
      moving_flag       <= 1'b0;
      wide_band_latched <= 1'b0;
    end else if (in_xfer) begin
      if (s_tuser) begin
        if (cmd_ok) begin
          target_slot  <= goal_slot;
          dir_flag     <= travel_dir;
          settled_flag <= 1'b0;
          moving_flag  <= 1'b0;
        end
      end else begin
        wide_band_latched <= wide_next;
        moving_flag       <= dec.outside;
        settled_flag      <= !dec.outside;
      end
    end
  end

  // Middle stage: decision for one tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_free) begin
      mid_valid <= tick_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_free && tick_xfer) begin
      mid.dec     <= dec;
      mid.ccw     <= dir_flag;
      mid.settled <= !dec.outside;
      mid.slot    <= target_slot;
    end
  end

  // Error to speed: 15 plus error * 65 / 18000, by reciprocal multiply.
  assign prod = PROD_W'(mid.dec.lim) * PROD_W'(SPEED_RECIP);
  assign quot = prod[PROD_W-1:RECIP_SH];
  assign mag  = $signed(SPEED_W'(quot)) + SPEED_MIN;

  always_comb begin
    if (!mid.dec.outside) begin
      speed_next = '0;
    end else if (mid.dec.crawl) begin
      speed_next = mid.ccw ? SPEED_MIN : -SPEED_MIN;
    end else begin
      speed_next = mid.ccw ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && mid_valid) begin
      m_tdata <= {(OUT_DATA_W - SPEED_W - 1 - SLOT_W)'(0), mid.slot, mid.settled,
                  speed_next};
    end
  end

  `ASSERT_NEVER(a_flags_exclusive, clk, rst, settled_flag && moving_flag)
  `ASSERT_AT(a_settled_zero_speed, clk, rst,
             (m_tvalid && m_tdata[SPEED_W]) |-> (m_tdata[SPEED_W-1:0] == '0))
  `ASSERT_AT(a_speed_range, clk, rst,
             m_tvalid |-> (($signed(m_tdata[SPEED_W-1:0]) <= SPEED_MAX) &&
                           ($signed(m_tdata[SPEED_W-1:0]) >= -SPEED_MAX)))
  `ASSERT_AT(a_cmd_clears_settled, clk, rst,
             (in_xfer && s_tuser && cmd_ok) |=> !settled_flag)
  `ASSERT_AT(a_tick_reaches_mid, clk, rst, tick_xfer |=> mid_valid)

endmodule

/* design/cpsl_err.sv */
`timescale 1ns / 1ps

module cpsl_err
  import cpsl_pkg::*;
(
  input  logic [ANGLE_W-1:0] ref_angle,
  input  logic [ANGLE_W-1:0] meas_angle,
  input  logic               ccw,
  input  logic               wide_band,
  output decision_t          dec
);

  logic signed [ERR_W-1:0] d_mr;
  logic signed [ERR_W-1:0] d_rm;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] rest;
  logic signed [ERR_W-1:0] band;

  assign d_mr = $signed(ERR_W'(meas_angle)) - $signed(ERR_W'(ref_angle));
  assign d_rm = $signed(ERR_W'(ref_angle)) - $signed(ERR_W'(meas_angle));

  // One-way error toward the target, wrapped once around the turn.
  always_comb begin
    if (ccw) begin
      err = (ref_angle >= meas_angle) ? d_rm : (TURN - d_mr);
    end else begin
      err = (ref_angle <= meas_angle) ? d_mr : (TURN - d_rm);
    end
  end

  assign rest = TURN - err;
  assign band = wide_band ? WIDE_BAND : NARROW_BAND;

  always_comb begin
    dec.outside = (err > band) && (rest > band);
    dec.crawl   = (rest <= CRAWL_ZONE);
    if (err[ERR_W-1]) begin
      dec.lim = '0;
    end else if (err > ERR_CLAMP) begin
      dec.lim = ERR_CLAMP[LIM_W-1:0];
    end else begin
      dec.lim = err[LIM_W-1:0];
    end
  end

endmodule
